### rtl/ffps_pkg.sv
// ----------------------------------------------------------------------------
// ffps_pkg
// Shared constants, types and helpers of the flow field particle step block.
// ----------------------------------------------------------------------------
package ffps_pkg;

    localparam int GRID_ROWS  = 16;
    localparam int GRID_COLS  = 16;
    localparam int GRID_DEPTH = 256;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);

    // integer part of (offset * scale) taken from the two partial products
    localparam int COORD_W    = 25;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIN_W      = 248;
    localparam int DOUT_W     = 160;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X  = 3'd0,
        REG_MIN_Y  = 3'd1,
        REG_WIDTH  = 3'd2,
        REG_HEIGHT = 3'd3,
        REG_COLS_X = 3'd4,
        REG_ROWS_Y = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic [30:0]        width;
        logic [30:0]        height;
        logic [31:0]        cols_x;
        logic [31:0]        rows_y;
    } cfg_t;

    typedef struct packed {
        logic               op;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] life;
        logic [15:0]        delta;
        logic [7:0]         cell_index;
        logic signed [31:0] flow_x;
        logic signed [31:0] flow_y;
    } item_t;

    typedef struct packed {
        logic               live;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] life;
        logic [15:0]        delta;
    } particle_t;

    typedef struct packed {
        logic               op;
        logic [ADDR_W-1:0]  addr;
        logic signed [31:0] flow_x;
        logic signed [31:0] flow_y;
        particle_t          p;
    } lookup_t;

    typedef struct packed {
        particle_t          p;
        logic signed [31:0] flow_x;
        logic signed [31:0] flow_y;
    } grid_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] life;
        logic               expired;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -35'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

### rtl/ffps_index.sv
// ----------------------------------------------------------------------------
// ffps_index
// Grid cell lookup: offset, scale multiply, clamp and cell address (3 stages).
// ----------------------------------------------------------------------------
module ffps_index (
    input  logic              clk,
    input  logic              rst_n,
    input  ffps_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  ffps_pkg::item_t   in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output ffps_pkg::lookup_t out_look
);
    import ffps_pkg::*;

    logic              a_valid_reg, b_valid_reg, c_valid_reg;
    logic              a_ready, b_ready, c_ready;
    item_t             a_item_reg, b_item_reg;
    logic              a_neg_x_reg, a_neg_y_reg, b_neg_x_reg, b_neg_y_reg;
    logic [31:0]       a_off_x_reg, a_off_y_reg;
    logic [32:0]       off_x_next, off_y_next;
    logic [47:0]       b_hi_x_reg, b_lo_x_reg, b_hi_y_reg, b_lo_y_reg;
    logic [48:0]       sum_x, sum_y;
    logic [COORD_W-1:0] c_x, c_y;
    logic [ADDR_W-1:0] col, row;
    logic [2*ADDR_W:0] lin;
    lookup_t           look_next, c_look_reg;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // stage A: offset from the range corner
    assign off_x_next = {in_item.pos_x[31], in_item.pos_x} - {cfg.min_x[31], cfg.min_x};
    assign off_y_next = {in_item.pos_y[31], in_item.pos_y} - {cfg.min_y[31], cfg.min_y};

    // stage C: integer part of offset * scale, clamp, cell address
    always_comb
    begin
        sum_x = 49'(b_hi_x_reg) + 49'(b_lo_x_reg[47:16]);
        sum_y = 49'(b_hi_y_reg) + 49'(b_lo_y_reg[47:16]);
        c_x   = sum_x[48:24];
        c_y   = sum_y[48:24];
        if (b_neg_x_reg)
            col = '0;
        else if (c_x >= COORD_W'(GRID_COLS))
            col = ADDR_W'(GRID_COLS - 1);
        else
            col = c_x[ADDR_W-1:0];
        if (b_neg_y_reg)
            row = '0;
        else if (c_y >= COORD_W'(GRID_ROWS))
            row = ADDR_W'(GRID_ROWS - 1);
        else
            row = c_y[ADDR_W-1:0];
        lin = (2*ADDR_W+1)'(row) * (2*ADDR_W+1)'(GRID_COLS) + (2*ADDR_W+1)'(col);

        look_next.op      = b_item_reg.op;
        look_next.addr    = (b_item_reg.op == OP_WRITE) ? ADDR_W'(b_item_reg.cell_index)
                                                        : lin[ADDR_W-1:0];
        look_next.flow_x  = b_item_reg.flow_x;
        look_next.flow_y  = b_item_reg.flow_y;
        look_next.p.live  = !b_item_reg.life[31] && (b_item_reg.life != 32'sd0);
        look_next.p.pos_x = b_item_reg.pos_x;
        look_next.p.pos_y = b_item_reg.pos_y;
        look_next.p.vel_x = b_item_reg.vel_x;
        look_next.p.vel_y = b_item_reg.vel_y;
        look_next.p.life  = b_item_reg.life;
        look_next.p.delta = b_item_reg.delta;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_item_reg  <= in_item;
            a_neg_x_reg <= off_x_next[32];
            a_neg_y_reg <= off_y_next[32];
            a_off_x_reg <= off_x_next[31:0];
            a_off_y_reg <= off_y_next[31:0];
        end
        if (b_ready && a_valid_reg)
        begin
            b_item_reg  <= a_item_reg;
            b_neg_x_reg <= a_neg_x_reg;
            b_neg_y_reg <= a_neg_y_reg;
            b_hi_x_reg  <= 48'(a_off_x_reg[31:16]) * 48'(cfg.cols_x);
            b_lo_x_reg  <= 48'(a_off_x_reg[15:0]) * 48'(cfg.cols_x);
            b_hi_y_reg  <= 48'(a_off_y_reg[31:16]) * 48'(cfg.rows_y);
            b_lo_y_reg  <= 48'(a_off_y_reg[15:0]) * 48'(cfg.rows_y);
        end
        if (c_ready && b_valid_reg)
            c_look_reg <= look_next;
    end

    assign out_valid = c_valid_reg;
    assign out_look  = c_look_reg;

endmodule

### rtl/ffps_grid.sv
// ----------------------------------------------------------------------------
// ffps_grid
// Flow vector memory: write requests store a cell, update requests read one.
// ----------------------------------------------------------------------------
module ffps_grid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ffps_pkg::lookup_t in_look,
    output logic              out_valid,
    input  logic              out_ready,
    output ffps_pkg::grid_t   out_grid
);
    import ffps_pkg::*;

    logic [63:0] flow_mem [GRID_DEPTH];
    logic [63:0] rd_data_reg;
    particle_t   d_p_reg;
    logic        d_valid_reg;
    logic        take;

    assign in_ready = !d_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (take && (in_look.op == OP_WRITE))
            flow_mem[in_look.addr] <= {in_look.flow_y, in_look.flow_x};
    end

    always_ff @(posedge clk)
    begin
        if (take && (in_look.op == OP_UPDATE))
        begin
            rd_data_reg <= flow_mem[in_look.addr];
            d_p_reg     <= in_look.p;
        end
    end

    // write requests end here and produce no result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (in_ready)
            d_valid_reg <= in_valid && (in_look.op == OP_UPDATE);
    end

    always_comb
    begin
        out_grid.p      = d_p_reg;
        out_grid.flow_x = rd_data_reg[31:0];
        out_grid.flow_y = rd_data_reg[63:32];
    end

    assign out_valid = d_valid_reg;

endmodule

### rtl/ffps_steer.sv
// ----------------------------------------------------------------------------
// ffps_steer
// Velocity steering toward the cell's flow vector (3 stages).
// ----------------------------------------------------------------------------
module ffps_steer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ffps_pkg::grid_t     in_grid,
    output logic                out_valid,
    input  logic                out_ready,
    output ffps_pkg::particle_t out_p
);
    import ffps_pkg::*;

    logic               e_valid_reg, f_valid_reg, g_valid_reg;
    logic               e_ready, f_ready, g_ready;
    particle_t          e_p_reg, f_p_reg, g_p_reg, p_next;
    logic signed [32:0] e_dx_reg, e_dy_reg, dx_next, dy_next;
    logic signed [49:0] f_prod_x_reg, f_prod_y_reg;
    logic signed [49:0] dt_e;

    assign g_ready  = !g_valid_reg || out_ready;
    assign f_ready  = !f_valid_reg || g_ready;
    assign e_ready  = !e_valid_reg || f_ready;
    assign in_ready = e_ready;

    assign dx_next = $signed({in_grid.flow_x[31], in_grid.flow_x})
                   - $signed({in_grid.p.vel_x[31], in_grid.p.vel_x});
    assign dy_next = $signed({in_grid.flow_y[31], in_grid.flow_y})
                   - $signed({in_grid.p.vel_y[31], in_grid.p.vel_y});
    assign dt_e    = 50'($signed({1'b0, e_p_reg.delta}));

    // add the floored step; a dead particle keeps its velocity
    always_comb
    begin
        p_next = f_p_reg;
        if (f_p_reg.live)
        begin
            p_next.vel_x = sat32(35'(f_p_reg.vel_x) + 35'($signed(f_prod_x_reg[49:16])));
            p_next.vel_y = sat32(35'(f_p_reg.vel_y) + 35'($signed(f_prod_y_reg[49:16])));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end
        else
        begin
            if (e_ready)
                e_valid_reg <= in_valid;
            if (f_ready)
                f_valid_reg <= e_valid_reg;
            if (g_ready)
                g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_ready && in_valid)
        begin
            e_p_reg  <= in_grid.p;
            e_dx_reg <= dx_next;
            e_dy_reg <= dy_next;
        end
        if (f_ready && e_valid_reg)
        begin
            f_p_reg      <= e_p_reg;
            f_prod_x_reg <= 50'(e_dx_reg) * dt_e;
            f_prod_y_reg <= 50'(e_dy_reg) * dt_e;
        end
        if (g_ready && f_valid_reg)
            g_p_reg <= p_next;
    end

    assign out_valid = g_valid_reg;
    assign out_p     = g_p_reg;

endmodule

### rtl/ffps_move.sv
// ----------------------------------------------------------------------------
// ffps_move
// Position step, wrap around the range, life update (3 stages).
// ----------------------------------------------------------------------------
module ffps_move (
    input  logic                clk,
    input  logic                rst_n,
    input  ffps_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  ffps_pkg::particle_t in_p,
    output logic                out_valid,
    input  logic                out_ready,
    output ffps_pkg::result_t   out_res
);
    import ffps_pkg::*;

    logic               h_valid_reg, i_valid_reg, j_valid_reg;
    logic               h_ready, i_ready, j_ready;
    particle_t          h_p_reg, i_p_reg;
    logic signed [48:0] h_prod_x_reg, h_prod_y_reg;
    logic signed [33:0] i_px_reg, i_py_reg, i_hi_x_reg, i_hi_y_reg;
    logic signed [34:0] wx, wy;
    logic signed [32:0] life_step;
    result_t            res_next, j_res_reg;

    assign j_ready  = !j_valid_reg || out_ready;
    assign i_ready  = !i_valid_reg || j_ready;
    assign h_ready  = !h_valid_reg || i_ready;
    assign in_ready = h_ready;

    // wrap once past either edge, then saturate
    always_comb
    begin
        if (i_px_reg > i_hi_x_reg)
            wx = 35'(i_px_reg) - 35'(cfg.width);
        else if (i_px_reg < 34'(cfg.min_x))
            wx = 35'(i_px_reg) + 35'(cfg.width);
        else
            wx = 35'(i_px_reg);
        if (i_py_reg > i_hi_y_reg)
            wy = 35'(i_py_reg) - 35'(cfg.height);
        else if (i_py_reg < 34'(cfg.min_y))
            wy = 35'(i_py_reg) + 35'(cfg.height);
        else
            wy = 35'(i_py_reg);

        life_step = 33'(i_p_reg.life) - 33'(i_p_reg.delta);

        res_next.vel_x = i_p_reg.vel_x;
        res_next.vel_y = i_p_reg.vel_y;
        if (i_p_reg.live)
        begin
            res_next.pos_x = sat32(wx);
            res_next.pos_y = sat32(wy);
            res_next.life  = life_step[31:0];
        end
        else
        begin
            res_next.pos_x = i_p_reg.pos_x;
            res_next.pos_y = i_p_reg.pos_y;
            res_next.life  = i_p_reg.life;
        end
        res_next.expired = res_next.life[31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
            j_valid_reg <= 1'b0;
        end
        else
        begin
            if (h_ready)
                h_valid_reg <= in_valid;
            if (i_ready)
                i_valid_reg <= h_valid_reg;
            if (j_ready)
                j_valid_reg <= i_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (h_ready && in_valid)
        begin
            h_p_reg      <= in_p;
            h_prod_x_reg <= 49'(in_p.vel_x) * 49'($signed({1'b0, in_p.delta}));
            h_prod_y_reg <= 49'(in_p.vel_y) * 49'($signed({1'b0, in_p.delta}));
        end
        if (i_ready && h_valid_reg)
        begin
            i_p_reg    <= h_p_reg;
            i_px_reg   <= 34'(h_p_reg.pos_x) + 34'($signed(h_prod_x_reg[48:16]));
            i_py_reg   <= 34'(h_p_reg.pos_y) + 34'($signed(h_prod_y_reg[48:16]));
            i_hi_x_reg <= $signed(34'(cfg.min_x) + 34'(cfg.width));
            i_hi_y_reg <= $signed(34'(cfg.min_y) + 34'(cfg.height));
        end
        if (j_ready && i_valid_reg)
            j_res_reg <= res_next;
    end

    assign out_valid = j_valid_reg;
    assign out_res   = j_res_reg;

endmodule

### rtl/flow_field_particle_step_top.sv
// Structure: a request passes through ten register stages before its result is
//   presented (lookup 3, grid memory 1, steering 3, move 3).
// Throughput: one request per cycle while the output is not stalled; every stage stalls independently.
// Write requests update the flow grid and produce no result.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the
//   register defaults; the flow grid holds no defined value until written.
// ----------------------------------------------------------------------------
// flow_field_particle_step_top
// Flow field particle step: grid lookup, velocity steering, move and wrap.
// ----------------------------------------------------------------------------
module flow_field_particle_step_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ffps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, life, delta, cell_index, flow_x, flow_y
    input  logic [ffps_pkg::DIN_W-1:0]      s_axis_tdata,
    // operation
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_life
    output logic [ffps_pkg::DOUT_W-1:0]     m_axis_tdata,
    // expired
    output logic                            m_axis_tuser
);
    import ffps_pkg::*;

    cfg_t      cfg_reg;
    item_t     in_item;
    lookup_t   look;
    grid_t     grid;
    particle_t steer_p;
    result_t   res;
    logic      look_valid, look_ready, grid_valid, grid_ready;
    logic      steer_valid, steer_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_x  <= 32'sd0;
            cfg_reg.min_y  <= 32'sd0;
            cfg_reg.width  <= 31'd67108864;
            cfg_reg.height <= 31'd67108864;
            cfg_reg.cols_x <= 32'd262144;
            cfg_reg.rows_y <= 32'd262144;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_X:  cfg_reg.min_x  <= cfg_data;
                REG_MIN_Y:  cfg_reg.min_y  <= cfg_data;
                REG_WIDTH:  cfg_reg.width  <= cfg_data[30:0];
                REG_HEIGHT: cfg_reg.height <= cfg_data[30:0];
                REG_COLS_X: cfg_reg.cols_x <= cfg_data;
                REG_ROWS_Y: cfg_reg.rows_y <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        in_item.op         = s_axis_tuser;
        in_item.pos_x      = s_axis_tdata[31:0];
        in_item.pos_y      = s_axis_tdata[63:32];
        in_item.vel_x      = s_axis_tdata[95:64];
        in_item.vel_y      = s_axis_tdata[127:96];
        in_item.life       = s_axis_tdata[159:128];
        in_item.delta      = s_axis_tdata[175:160];
        in_item.cell_index = s_axis_tdata[183:176];
        in_item.flow_x     = s_axis_tdata[215:184];
        in_item.flow_y     = s_axis_tdata[247:216];
    end

    ffps_index u_index (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (look_valid),
        .out_ready (look_ready),
        .out_look  (look)
    );

    ffps_grid u_grid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (look_valid),
        .in_ready  (look_ready),
        .in_look   (look),
        .out_valid (grid_valid),
        .out_ready (grid_ready),
        .out_grid  (grid)
    );

    ffps_steer u_steer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (grid_valid),
        .in_ready  (grid_ready),
        .in_grid   (grid),
        .out_valid (steer_valid),
        .out_ready (steer_ready),
        .out_p     (steer_p)
    );

    ffps_move u_move (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (steer_valid),
        .in_ready  (steer_ready),
        .in_p      (steer_p),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {res.life, res.vel_y, res.vel_x, res.pos_y, res.pos_x};
    assign m_axis_tuser = res.expired;

endmodule

### rtl/ffps_checker.sv
// ----------------------------------------------------------------------------
// ffps_checker
// Port-level checks of the flow field particle step block, bound to the top.
// ----------------------------------------------------------------------------
module ffps_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [ffps_pkg::DOUT_W-1:0] m_axis_tdata,
    input logic                        m_axis_tuser
);
    import ffps_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // expired flag follows the sign of the new life
    a_expired: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == m_axis_tdata[DOUT_W-1]))
        else $error("expired flag disagrees with new_life");

    // with the output register empty, no stage can hold back a request
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result present right after reset");

endmodule

bind flow_field_particle_step_top ffps_checker u_ffps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
